### rtl/dtfp_pkg.sv
// Shared widths, defaults, status types and the power-of-ten table of the decimal parser.
`timescale 1ns / 1ps
`default_nettype none

package dtfp_pkg;

  localparam int unsigned CHAR_W              = 8;
  localparam int unsigned VALUE_W             = 31;
  localparam int unsigned ACC_W               = 32;
  localparam int unsigned DEN_W               = 30;
  localparam int unsigned CNT_W               = 4;
  localparam int unsigned DEF_MAX_FRAC_DIGITS = 9;
  localparam int unsigned DEF_FRAC_BITS       = 28;

  typedef struct packed {
    logic busy;
    logic done;
  } dtfp_div_stat_t;

  // 10**n for n = 0..9; larger counts clamp to 10**9
  function automatic logic [DEN_W-1:0] pow_ten(input logic [CNT_W-1:0] n);
    logic [DEN_W-1:0] r;
    case (n)
      4'd0:    r = DEN_W'(1);
      4'd1:    r = DEN_W'(10);
      4'd2:    r = DEN_W'(100);
      4'd3:    r = DEN_W'(1000);
      4'd4:    r = DEN_W'(10000);
      4'd5:    r = DEN_W'(100000);
      4'd6:    r = DEN_W'(1000000);
      4'd7:    r = DEN_W'(10000000);
      4'd8:    r = DEN_W'(100000000);
      default: r = DEN_W'(1000000000);
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/dtfp_if.sv
// Valid/ready channel interfaces for the character input and the result output.
`timescale 1ns / 1ps
`default_nettype none

interface dtfp_in_if import dtfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface dtfp_out_if import dtfp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      out_of_range;

  modport source (output valid, output value, output out_of_range, input ready);
  modport sink   (input valid, input value, input out_of_range, output ready);
endinterface

`default_nettype wire

### rtl/dtfp_div.sv
// Restoring radix-2 divider: one quotient bit per cycle for the final fixed-point scaling.
`timescale 1ns / 1ps
`default_nettype none

module dtfp_div import dtfp_pkg::*; #(
  parameter int unsigned FRAC_BITS = DEF_FRAC_BITS
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire logic [ACC_W-1:0]       acc_i,
  input  wire logic [DEN_W-1:0]       den_i,
  output logic      [FRAC_BITS+1:0]   quot_o,
  output dtfp_div_stat_t              stat_o
);

  localparam int unsigned Q_W   = FRAC_BITS + 2;
  localparam int unsigned NUM_W = ACC_W + FRAC_BITS + 1;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned STEP_W = $clog2(Q_W);

  logic [REM_W-1:0]  rem_q, rem_d;
  logic [Q_W-1:0]    sh_q, sh_d;
  logic [DEN_W-1:0]  den_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  logic [NUM_W-1:0]  num;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              ge;

  // numerator = (acc << FRAC_BITS) + den / 2; quotient fits in Q_W bits when in range,
  // so the top part seeds the remainder and only the low Q_W bits are shifted in
  assign num   = (NUM_W'(acc_i) << FRAC_BITS) + NUM_W'(den_i >> 1);
  assign trial = {rem_q, sh_q[Q_W-1]};
  assign ge    = trial >= (REM_W+1)'(den_q);
  assign diff  = trial - (REM_W+1)'(den_q);

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      rem_d  = num[Q_W +: REM_W];
      sh_d   = num[Q_W-1:0];
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      rem_d  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
      sh_d   = {sh_q[Q_W-2:0], ge};
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(Q_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign quot_o      = sh_q;
  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;

`ifndef SYNTHESIS
  a_busy_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy_q && done_q))
    else $error("divider busy and done at once");

  a_done_after_last_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && step_q == STEP_W'(Q_W - 1)) |=> done_q)
    else $error("divider missed done after last step");

  a_step_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> step_q <= STEP_W'(Q_W - 1))
    else $error("divider step counter past end");
`endif

endmodule

`default_nettype wire

### rtl/decimal_text_to_fixed_parser.sv
// Top level: character sequencer of the decimal text to Q2.FRAC_BITS parser.
// Flow: a character that does not end the number only updates the parse state; the ending
//   character starts the shared divider, and the result is registered once the divider is done.
// Throughput: 1 character per cycle inside a number; the input stalls during the one divide,
//   run by the radix-2 divider (one quotient bit per cycle), until the result is loaded.
// Reset: rst_ni is asynchronous, active low; it returns to the whitespace phase, empties
//   the output register and idles the divider.
`timescale 1ns / 1ps
`default_nettype none

module decimal_text_to_fixed_parser import dtfp_pkg::*; #(
  parameter int unsigned MAX_FRAC_DIGITS = DEF_MAX_FRAC_DIGITS,
  parameter int unsigned FRAC_BITS       = DEF_FRAC_BITS
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  dtfp_in_if.sink   in_ch_i,
  dtfp_out_if.source out_ch_o
);

  localparam int unsigned Q_W = FRAC_BITS + 2;

  // parse phases
  localparam logic [1:0] PH_WS   = 2'd0;
  localparam logic [1:0] PH_INT  = 2'd1;
  localparam logic [1:0] PH_FRAC = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // sequencer states
  localparam logic ST_PARSE = 1'b0;
  localparam logic ST_DIV   = 1'b1;

  // character codes
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;

  localparam logic signed [VALUE_W-1:0] LIMIT = VALUE_W'(2) << FRAC_BITS;

  // parse state
  logic [1:0]       phase_q, phase_d;
  logic             neg_q, neg_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             ovf_q, ovf_d;

  // sequencer and result capture
  logic             state_q, state_d;
  logic             res_neg_q;
  logic             res_over_q;

  // output register
  logic                      out_valid_q;
  logic signed [VALUE_W-1:0] value_q;
  logic                      oor_q;

  // character decode
  logic [CHAR_W-1:0] c;
  logic              last;
  logic              is_space, is_digit;
  logic [3:0]        dval;
  logic [CHAR_W-1:0] dsub;
  logic [ACC_W+3:0]  acc_mac;
  logic              ends;
  logic              emit;
  logic              accept;

  // emit datapath
  logic [DEN_W-1:0]  den;
  logic              over;

  // divider
  logic               div_start;
  logic [Q_W-1:0]     quot;
  dtfp_div_stat_t     div_st;

  logic                      out_free;
  logic                      out_load;
  logic [VALUE_W-1:0]        mag;
  logic [VALUE_W-1:0]        mag_signed;

  assign c        = in_ch_i.char_code;
  assign last     = in_ch_i.end_of_text;
  assign accept   = in_ch_i.valid && in_ch_i.ready;
  assign is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  assign dsub     = c - CH_ZERO;
  assign dval     = dsub[3:0];
  // acc * 10 + digit, one shared multiply-add for both digit kinds
  assign acc_mac  = ((ACC_W+4)'(acc_q) << 3) + ((ACC_W+4)'(acc_q) << 1) + (ACC_W+4)'(dval);

  // advance the parse state for one character
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    ovf_d   = ovf_q;
    ends    = 1'b0;
    case (phase_q)
      PH_WS: begin
        if (is_space) begin
          phase_d = PH_WS;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          neg_d   = (c == CH_MINUS);
          phase_d = PH_INT;
        end else if (is_digit) begin
          phase_d = PH_INT;
          if (acc_mac > (ACC_W+4)'(2)) begin
            acc_d = ACC_W'(3);
            ovf_d = 1'b1;
          end else begin
            acc_d = acc_mac[ACC_W-1:0];
          end
        end else if (c == CH_POINT) begin
          phase_d = PH_FRAC;
        end else begin
          ends = 1'b1;
        end
      end
      PH_INT: begin
        if (is_digit) begin
          // saturate the integer part at 3 once it passes 2
          if (acc_mac > (ACC_W+4)'(2)) begin
            acc_d = ACC_W'(3);
            ovf_d = 1'b1;
          end else begin
            acc_d = acc_mac[ACC_W-1:0];
          end
        end else if (c == CH_POINT) begin
          phase_d = PH_FRAC;
        end else begin
          ends = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit) begin
          // drop fraction digits beyond the limit
          if (cnt_q < CNT_W'(MAX_FRAC_DIGITS)) begin
            acc_d = acc_mac[ACC_W-1:0];
            cnt_d = cnt_q + CNT_W'(1);
          end
        end else begin
          ends = 1'b1;
        end
      end
      default: begin
        phase_d = phase_q;
      end
    endcase
  end

  // one result per number: on the ending character, or on the last character of the text
  assign emit = (phase_q != PH_DONE) && (ends || last);
  assign den  = pow_ten(cnt_d);
  assign over = ovf_d || ((ACC_W+1)'(acc_d) > ((ACC_W+1)'(den) << 1));

  assign div_start = accept && emit;

  dtfp_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .acc_i   (acc_d),
    .den_i   (den),
    .quot_o  (quot),
    .stat_o  (div_st)
  );

  // hold the finished quotient until the output register frees up
  assign out_free = !out_valid_q || out_ch_o.ready;
  assign out_load = (state_q == ST_DIV) && div_st.done && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_PARSE: begin
        if (div_start) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (out_load) begin
          state_d = ST_PARSE;
        end
      end
      default: begin
        state_d = ST_PARSE;
      end
    endcase
  end

  // saturate out-of-range numbers, then apply the sign (negative zero gives zero)
  assign mag        = res_over_q ? LIMIT : {{(VALUE_W-Q_W){1'b0}}, quot};
  assign mag_signed = res_neg_q ? (VALUE_W'(0) - mag) : mag;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_WS;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      state_q     <= ST_PARSE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        if (last) begin
          // drop the whole parse state after the last character of the text
          phase_q <= PH_WS;
          neg_q   <= 1'b0;
          acc_q   <= '0;
          cnt_q   <= '0;
          ovf_q   <= 1'b0;
        end else begin
          phase_q <= emit ? PH_DONE : phase_d;
          neg_q   <= neg_d;
          acc_q   <= acc_d;
          cnt_q   <= cnt_d;
          ovf_q   <= ovf_d;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      res_neg_q  <= neg_d;
      res_over_q <= over;
    end
    if (out_load) begin
      value_q <= mag_signed;
      oor_q   <= res_over_q;
    end
  end

  assign in_ch_i.ready         = (state_q == ST_PARSE);
  assign out_ch_o.valid        = out_valid_q;
  assign out_ch_o.value        = value_q;
  assign out_ch_o.out_of_range = oor_q;

`ifndef SYNTHESIS
  a_start_idle_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_st.busy)
    else $error("divider restarted while busy");

  a_div_state_tracks_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_st.busy || div_st.done))
    else $error("waiting on an idle divider");

  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ($signed(value_q) <= LIMIT && $signed(value_q) >= -LIMIT))
    else $error("result magnitude above limit");

  a_oor_saturated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && oor_q) |-> (value_q == LIMIT || value_q == -LIMIT))
    else $error("out-of-range result not saturated");
`endif

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the decimal text to Q2.28 fixed-point parser.
`timescale 1ns / 1ps

module tb;
  import dtfp_pkg::*;

  localparam int unsigned FRAC_W       = DEF_FRAC_BITS;
  localparam int unsigned MAX_FD       = DEF_MAX_FRAC_DIGITS;
  localparam int unsigned RESET_CYCLES = 12;
  // Drain time: covers the divide of the last number, with margin on top.
  localparam int unsigned DRAIN_CYCLES = FRAC_W + 12;
  // Longer than the receiver hold-off below, and far longer than any normal stall.
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned TARGET_CHARS = 1900;

  // Character codes the parser reacts to.
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [1:0] {
    SCAN_SPACE,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_DONE
  } scan_phase_e;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } text_char_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               out_of_range;
  } fixed_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dtfp_in_if  in_ch ();
  dtfp_out_if out_ch ();

  decimal_text_to_fixed_parser #(
    .MAX_FRAC_DIGITS(MAX_FD),
    .FRAC_BITS      (FRAC_W)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Parser shadow: mirrors the block's scan state for every accepted character.
  // ---------------------------------------------------------------------------
  scan_phase_e   scan_phase;
  logic          sign_neg;
  logic [63:0]   digit_acc;
  int unsigned   frac_count;
  logic          int_over;

  fixed_result_t expected_numbers[$];
  text_char_t    pending_chars[$];
  int unsigned   mismatch_count;

  function automatic logic is_blank(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  task automatic clear_scan();
    scan_phase = SCAN_SPACE;
    sign_neg   = 1'b0;
    digit_acc  = '0;
    frac_count = 0;
    int_over   = 1'b0;
  endtask

  // Integer part saturates at 3 once it passes 2; the number is then out of range.
  task automatic take_int_digit(input logic [CHAR_W-1:0] c);
    digit_acc = digit_acc * 10 + 64'(c - CH_ZERO);
    if (digit_acc > 2) begin
      digit_acc = 64'd3;
      int_over  = 1'b1;
    end
  endtask

  // Scale the decimal accumulator by 10**-count into Q2.FRAC_W, round half away
  // from zero (done on the magnitude), clamp to 2, then apply the sign.
  function automatic fixed_result_t scale_to_fixed();
    logic [63:0]   den;
    logic [63:0]   mag;
    logic [63:0]   limit;
    int unsigned   n;
    fixed_result_t r;
    n     = (frac_count > 9) ? 9 : frac_count;
    den   = 64'd1;
    limit = 64'd2 << FRAC_W;
    for (int k = 0; k < n; k++) den = den * 10;
    r.out_of_range = int_over || (digit_acc > 2 * den);
    if (r.out_of_range) begin
      mag = limit;
    end else begin
      mag = ((digit_acc << FRAC_W) + den / 2) / den;
      if (mag > limit) mag = limit;
    end
    if (sign_neg) mag = -mag;
    r.value = mag[VALUE_W-1:0];
    return r;
  endfunction

  task automatic parse_char(input logic [CHAR_W-1:0] c, input logic last);
    logic ends;
    ends = 1'b0;
    case (scan_phase)
      SCAN_SPACE: begin
        if (is_blank(c)) begin
          // keep skipping
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          sign_neg   = (c == CH_MINUS);
          scan_phase = SCAN_INT;
        end else if (is_digit(c)) begin
          take_int_digit(c);
          scan_phase = SCAN_INT;
        end else if (c == CH_POINT) begin
          scan_phase = SCAN_FRAC;
        end else begin
          ends = 1'b1;
        end
      end
      SCAN_INT: begin
        if (is_digit(c)) take_int_digit(c);
        else if (c == CH_POINT) scan_phase = SCAN_FRAC;
        else ends = 1'b1;
      end
      SCAN_FRAC: begin
        if (is_digit(c)) begin
          // digits past the limit are swallowed without effect
          if (frac_count < MAX_FD && frac_count < 9) begin
            digit_acc  = digit_acc * 10 + 64'(c - CH_ZERO);
            frac_count = frac_count + 1;
          end
        end else begin
          ends = 1'b1;
        end
      end
      default: begin
        // after the number: ignore until end of text
      end
    endcase
    if (scan_phase != SCAN_DONE && (ends || last)) begin
      expected_numbers.push_back(scale_to_fixed());
      scan_phase = SCAN_DONE;
    end
    if (last) clear_scan();
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus builders: append characters to the sender's queue.
  // ---------------------------------------------------------------------------
  task automatic put_char(input logic [CHAR_W-1:0] c, input logic last);
    text_char_t t;
    t.code = c;
    t.last = last;
    pending_chars.push_back(t);
  endtask

  task automatic queue_text(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i], i == s.len() - 1);
  endtask

  function automatic logic [CHAR_W-1:0] rand_digit(input logic small_bias);
    if (small_bias && $urandom_range(0, 9) < 7) return CH_ZERO + 8'($urandom_range(0, 2));
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed numbers with random content; some pure noise texts.
  task automatic queue_random_text();
    logic [CHAR_W-1:0] buf_q[$];
    int unsigned       n;
    int unsigned       i;
    if ($urandom_range(0, 99) < 15) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) put_char(8'($urandom_range(0, 255)), i == n - 1);
    end else begin
      n = $urandom_range(0, 2);
      for (i = 0; i < n; i++)
        buf_q.push_back(($urandom_range(0, 6) == 0) ? CH_SPACE : 8'($urandom_range(9, 13)));
      if ($urandom_range(0, 1) != 0)
        buf_q.push_back(($urandom_range(0, 1) != 0) ? CH_MINUS : CH_PLUS);
      n = ($urandom_range(0, 9) < 2) ? 3 : $urandom_range(0, 2);
      for (i = 0; i < n; i++) buf_q.push_back(rand_digit(1'b1));
      if ($urandom_range(0, 9) < 7) begin
        buf_q.push_back(CH_POINT);
        n = $urandom_range(0, 11);
        for (i = 0; i < n; i++) buf_q.push_back(rand_digit(1'b0));
      end
      // explicit terminator plus trailing junk, or let end of text close the number
      if ($urandom_range(0, 1) != 0) begin
        n = $urandom_range(1, 3);
        for (i = 0; i < n; i++) buf_q.push_back(8'($urandom_range(0, 255)));
      end
      if (buf_q.size() == 0) buf_q.push_back(CH_SPACE);
      for (i = 0; i < buf_q.size(); i++) put_char(buf_q[i], i == buf_q.size() - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Character sender: changes inputs on the falling edge only.
  // ---------------------------------------------------------------------------
  logic        char_taken;
  logic        char_busy;
  text_char_t  offered_char;
  int unsigned char_gap;
  int unsigned src_gap_max;
  int unsigned chars_sent;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (char_busy && char_taken) begin
        char_busy  = 1'b0;
        chars_sent = chars_sent + 1;
        // switch between gap-free bursts and idle-heavy stretches
        if (chars_sent % 64 == 0) src_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
        char_gap = $urandom_range(0, src_gap_max);
      end
      if (!char_busy) begin
        if (char_gap != 0) begin
          char_gap = char_gap - 1;
        end else if (pending_chars.size() != 0) begin
          offered_char = pending_chars.pop_front();
          char_busy    = 1'b1;
        end
      end
      in_ch.valid <= char_busy;
      if (char_busy) begin
        in_ch.char_code   <= offered_char.code;
        in_ch.end_of_text <= offered_char.last;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls per item, and one long hold-off that lets the
  // block fill up and push back on the character channel.
  // ---------------------------------------------------------------------------
  logic        result_taken;
  int unsigned ready_wait;
  int unsigned snk_gap_max;
  int unsigned results_seen;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (result_taken) begin
        results_seen = results_seen + 1;
        if (results_seen % 32 == 0) snk_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
        ready_wait = (results_seen == HOLD_AT) ? HOLD_CYCLES : $urandom_range(0, snk_gap_max);
      end
      if (ready_wait != 0) begin
        ready_wait = ready_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted characters, check accepted results, and guard
  // against a hang.
  // ---------------------------------------------------------------------------
  fixed_result_t want;
  int unsigned   quiet_cycles;

  always @(posedge clk_i) begin
    char_taken   <= in_ch.valid && in_ch.ready;
    result_taken <= out_ch.valid && out_ch.ready;
    if (rst_ni) begin
      if (in_ch.valid && in_ch.ready) parse_char(in_ch.char_code, in_ch.end_of_text);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_numbers.size() == 0) begin
          $display("%0t: unexpected result, expected none, got value %0d out_of_range %0b",
                   $time, out_ch.value, out_ch.out_of_range);
          mismatch_count = mismatch_count + 1;
        end else begin
          want = expected_numbers.pop_front();
          if (out_ch.value !== want.value) begin
            $display("%0t: value expected %0d, got %0d",
                     $time, $signed(want.value), out_ch.value);
            mismatch_count = mismatch_count + 1;
          end
          if (out_ch.out_of_range !== want.out_of_range) begin
            $display("%0t: out_of_range expected %0b, got %0b",
                     $time, want.out_of_range, out_ch.out_of_range);
            mismatch_count = mismatch_count + 1;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
      else quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: build the stimulus, reset once, run, drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.char_code    = '0;
    in_ch.end_of_text  = 1'b0;
    out_ch.ready       = 1'b0;
    char_taken         = 1'b0;
    result_taken       = 1'b0;
    char_busy          = 1'b0;
    char_gap           = 0;
    chars_sent         = 0;
    src_gap_max        = 5;
    ready_wait         = 0;
    snk_gap_max        = 5;
    results_seen       = 0;
    quiet_cycles       = 0;
    mismatch_count     = 0;
    clear_scan();

    // Directed texts first.
    queue_text("2");               // exactly two stays in range
    queue_text("-0");              // negative zero
    put_char(CH_PLUS, 1'b0);       // sign then point, ended by a NUL byte,
    put_char(CH_POINT, 1'b0);      // then a junk byte that only closes the text
    put_char("5", 1'b0);
    put_char(8'h00, 1'b0);
    put_char(8'h7F, 1'b1);
    put_char(CH_TAB, 1'b0);        // whitespace, then an integer part above two
    put_char("3", 1'b1);
    put_char(8'hFF, 1'b1);         // no digits at all
    put_char(CH_CR, 1'b1);         // whitespace only, closed by end of text
    queue_text(" .1234567891");    // point right after whitespace, excess fraction digits

    while (pending_chars.size() < TARGET_CHARS) queue_random_text();

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (pending_chars.size() == 0 && !char_busy);
    wait (expected_numbers.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
